>>> src/ili_pkg.sv
// Shared constants, request codes and the shift control bundle for the indexed list.
package ili_pkg;

  localparam int DATA_W      = 32;
  localparam int MODE_W      = 3;
  localparam int INDEX_W     = 7;
  localparam int COUNT_W     = 7;
  localparam int CAP_DEFAULT = 64;
  localparam int CAP_MAX     = 1024;
  localparam int POS_W       = $clog2(CAP_MAX + 1);
  localparam int GROUP       = 8;
  localparam int GSEL_W      = $clog2(GROUP);

  localparam logic [MODE_W-1:0] MODE_READ      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INS_FRONT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INS_BACK  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_INS_AT    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_AT    = 3'd4;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } shift_ctl_t;

endpackage

>>> src/ili_cell.sv
// One storage cell of the list: holds one element and shifts with its neighbors.
module ili_cell #(
  parameter int K = 0
) (
  input  logic                        clk,
  input  ili_pkg::shift_ctl_t         ctl,
  input  logic [ili_pkg::DATA_W-1:0]  left_i,
  input  logic [ili_pkg::DATA_W-1:0]  right_i,
  output logic [ili_pkg::DATA_W-1:0]  value_o
);

  localparam logic [ili_pkg::POS_W-1:0] KP = ili_pkg::POS_W'(K);

  logic [ili_pkg::DATA_W-1:0] value_r;
  logic [ili_pkg::DATA_W-1:0] value_nxt;

  always_comb begin
    value_nxt = value_r;
    if (ctl.ins) begin
      if (KP > ctl.pos) begin
        value_nxt = left_i;
      end else if (KP == ctl.pos) begin
        value_nxt = ctl.value;
      end
    end else if (ctl.del && (KP >= ctl.pos)) begin
      value_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_o = value_r;

endmodule

>>> src/indexed_list_insert_delete.sv
// Top level of the indexed list: request decode, cell row, read select and result.
// A request is taken when start is high and busy is low; the row of cells shifts and a
// read picks one element within each group of eight at that edge, and in the next cycle
// busy is high and the result stands on the out_ ports for exactly that cycle with
// out_valid high. The two-level read select picks within each group before that edge and
// among the groups after it. The receiver cannot stall, so a result must be taken when shown.
module indexed_list_insert_delete #(
  parameter int CAPACITY = ili_pkg::CAP_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ili_pkg::MODE_W-1:0]    in_mode,
  input  logic [ili_pkg::INDEX_W-1:0]   in_index,
  input  logic signed [ili_pkg::DATA_W-1:0] in_value,
  output logic                          out_valid,
  output logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  output logic                          out_hit,
  output logic                          out_applied,
  output logic [ili_pkg::COUNT_W-1:0]   out_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int NG    = (CAPACITY + ili_pkg::GROUP - 1) / ili_pkg::GROUP;
  localparam int HI_W  = ili_pkg::INDEX_W - ili_pkg::GSEL_W;
  localparam logic [ili_pkg::POS_W-1:0] CAP_P = ili_pkg::POS_W'(CAPACITY);

  logic                         busy_r;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         hit_r, applied_r, miss_r;
  logic [HI_W-1:0]              hi_r;
  logic [ili_pkg::DATA_W-1:0]   grp_r   [NG];
  logic [ili_pkg::DATA_W-1:0]   grp_nxt [NG];
  logic [ili_pkg::DATA_W-1:0]   cell_q  [CAPACITY];

  logic                         accept;
  logic [ili_pkg::POS_W-1:0]    cnt_p, idx_p, pos_eff;
  logic                         is_ins, ins_ok, del_ok, rd_ok, rd_miss;
  ili_pkg::shift_ctl_t          ctl;
  logic [ili_pkg::DATA_W-1:0]   sel_value;

  assign accept = start && !busy_r;
  assign cnt_p  = ili_pkg::POS_W'(count_r);
  assign idx_p  = ili_pkg::POS_W'(in_index);

  always_comb begin
    is_ins  = 1'b0;
    pos_eff = idx_p;
    unique case (in_mode)
      ili_pkg::MODE_INS_FRONT: begin
        is_ins  = 1'b1;
        pos_eff = '0;
      end
      ili_pkg::MODE_INS_BACK: begin
        is_ins  = 1'b1;
        pos_eff = cnt_p;
      end
      ili_pkg::MODE_INS_AT: begin
        is_ins  = 1'b1;
      end
      default: begin
        is_ins  = 1'b0;
      end
    endcase
  end

  assign ins_ok  = accept && is_ins && (cnt_p < CAP_P) && (pos_eff <= cnt_p);
  assign del_ok  = accept && (in_mode == ili_pkg::MODE_DEL_AT) && (idx_p < cnt_p);
  assign rd_ok   = (in_mode == ili_pkg::MODE_READ) && (idx_p < cnt_p);
  assign rd_miss = (in_mode == ili_pkg::MODE_READ) && !(idx_p < cnt_p);

  always_comb begin
    ctl.ins   = ins_ok;
    ctl.del   = del_ok;
    ctl.pos   = pos_eff;
    ctl.value = in_value;
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [ili_pkg::DATA_W-1:0] left_v, right_v;
    if (k == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_q[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_q[k+1];
    end
    ili_cell #(.K(k)) u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .left_i  (left_v),
      .right_i (right_v),
      .value_o (cell_q[k])
    );
  end

  always_comb begin
    for (int j = 0; j < NG; j++) begin
      grp_nxt[j] = '0;
      for (int b = 0; b < ili_pkg::GROUP; b++) begin
        if ((j * ili_pkg::GROUP + b < CAPACITY) &&
            (int'(in_index[ili_pkg::GSEL_W-1:0]) == b)) begin
          grp_nxt[j] = cell_q[j * ili_pkg::GROUP + b];
        end
      end
    end
  end

  always_comb begin
    sel_value = '0;
    for (int j = 0; j < NG; j++) begin
      if (int'(hi_r) == j) begin
        sel_value = grp_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      count_r   <= '0;
      hit_r     <= 1'b0;
      applied_r <= 1'b0;
      miss_r    <= 1'b0;
    end else begin
      busy_r  <= accept;
      count_r <= count_nxt;
      if (accept) begin
        hit_r     <= rd_ok;
        applied_r <= rd_ok || ins_ok || del_ok;
        miss_r    <= rd_miss;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hi_r <= in_index[ili_pkg::INDEX_W-1:ili_pkg::GSEL_W];
      for (int j = 0; j < NG; j++) begin
        grp_r[j] <= grp_nxt[j];
      end
    end
  end

  assign busy           = busy_r;
  assign out_valid      = busy_r;
  assign out_hit        = hit_r;
  assign out_applied    = applied_r;
  assign out_count      = ili_pkg::COUNT_W'(count_r);
  assign out_read_value = hit_r ? sel_value : (miss_r ? '1 : '0);

endmodule

>>> src/ili_checker.sv
// Port-level checks of the indexed list and their binding to the top level.
module ili_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              start,
  input logic                              busy,
  input logic [ili_pkg::MODE_W-1:0]        in_mode,
  input logic                              out_valid,
  input logic signed [ili_pkg::DATA_W-1:0] out_read_value,
  input logic                              out_hit,
  input logic                              out_applied,
  input logic [ili_pkg::COUNT_W-1:0]       out_count
);

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> out_valid)
    else $error("request not answered in the next cycle");

  a_busy_single: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_hit_applied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_applied && (out_count != '0))
    else $error("hit on an empty list or without applied");

  a_read_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit && ($past(in_mode) == ili_pkg::MODE_READ) |->
      (out_read_value == -32'sd1) && !out_applied)
    else $error("read miss did not return minus one");

endmodule

bind indexed_list_insert_delete ili_checker u_ili_checker (.*);
